FILE: design/assert_macros.svh
// Concurrent assertion helpers, clocked on clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: assertion failed");
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

FILE: design/ccc_pkg.sv
package ccc_pkg;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      digit_type tens;
      digit_type units;
   } bcd_pair_type;

   typedef logic [3:0][3:0] year_bcd_type;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_CHAR   = 2'd1;
   localparam logic [1:0] ACT_MODE   = 2'd2;
   localparam logic [1:0] ACT_SCREEN = 2'd3;

   localparam logic [1:0] CSR_TICKS_PER_SECOND = 2'd0;
   localparam logic [1:0] CSR_DAYS_PER_MONTH   = 2'd1;
   localparam logic [1:0] CSR_MONTHS_PER_YEAR  = 2'd2;

   localparam digit_type  DIGIT_DASH = 4'd10;
   localparam logic [3:0] FRAME_LAST = 4'd13;

   typedef struct packed {
      logic [7:0] ticks_per_second;
      logic [4:0] days_per_month;
      logic [6:0] months_per_year;
   } csr_type;

   typedef struct packed {
      logic         load;
      bcd_pair_type hours;
      bcd_pair_type minutes;
      bcd_pair_type seconds;
      bcd_pair_type days;
      bcd_pair_type months;
      year_bcd_type year;
   } frame_load_type;

   typedef struct packed {
      digit_type digit_a;
      digit_type digit_b;
      digit_type digit_c;
      digit_type digit_d;
      digit_type digit_e;
      digit_type digit_f;
      digit_type digit_g;
      digit_type digit_h;
      logic      shows_date;
      logic      display_on;
      logic      refresh;
   } result_type;

endpackage

FILE: design/ccc_frame_rx.sv
`include "assert_macros.svh"

module ccc_frame_rx (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    char_valid,
   input  logic [7:0]              serial_char,
   output ccc_pkg::frame_load_type frame
);

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   logic [3:0]         position_ff;
   logic [3:0]         position_in;
   logic               bad_ff;
   logic               bad_in;
   ccc_pkg::digit_type digits_ff [13];
   logic               is_digit;
   logic               at_last;
   ccc_pkg::digit_type value;

   assign is_digit = (serial_char >= CHAR_ZERO) && (serial_char <= CHAR_NINE);
   assign value    = is_digit ? serial_char[3:0] : 4'd0;
   assign at_last  = (position_ff == ccc_pkg::FRAME_LAST);

   always_comb begin
      position_in = position_ff;
      bad_in      = bad_ff;
      if (char_valid) begin
         if (at_last) begin
            position_in = 4'd0;
            bad_in      = 1'b0;
         end else begin
            position_in = position_ff + 4'd1;
            bad_in      = bad_ff | ~is_digit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 4'd0;
         bad_ff      <= 1'b0;
      end else begin
         position_ff <= position_in;
         bad_ff      <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_valid && !at_last) begin
         digits_ff[position_ff] <= value;
      end
   end

   assign frame.load    = char_valid && at_last && !bad_ff && is_digit;
   assign frame.hours   = '{tens: digits_ff[0], units: digits_ff[1]};
   assign frame.minutes = '{tens: digits_ff[2], units: digits_ff[3]};
   assign frame.seconds = '{tens: digits_ff[4], units: digits_ff[5]};
   assign frame.days    = '{tens: digits_ff[6], units: digits_ff[7]};
   assign frame.months  = '{tens: digits_ff[8], units: digits_ff[9]};
   assign frame.year    = {digits_ff[10], digits_ff[11], digits_ff[12], value};

   `ASSERT_NEVER(a_position_range, position_ff > ccc_pkg::FRAME_LAST)
   `ASSERT_CLK(a_load_at_end, frame.load |=> (position_ff == 4'd0) && !bad_ff)
   `ASSERT_CLK(a_bad_blocks_load, (bad_ff && at_last) |-> !frame.load)

endmodule

FILE: design/ccc_time_core.sv
module ccc_time_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [1:0]              action,
   input  ccc_pkg::frame_load_type frame,
   input  ccc_pkg::csr_type        csr,
   output ccc_pkg::result_type     result
);

   localparam ccc_pkg::bcd_pair_type PAIR_ZERO  = '{tens: 4'd0, units: 4'd0};
   localparam ccc_pkg::bcd_pair_type PAIR_ONE   = '{tens: 4'd0, units: 4'd1};
   localparam ccc_pkg::year_bcd_type YEAR_RESET = 16'h1971;

   function automatic logic [6:0] pair_value(input ccc_pkg::bcd_pair_type p);
      return {p.tens, 3'b000} + {2'b00, p.tens, 1'b0} + {3'b000, p.units};
   endfunction

   function automatic ccc_pkg::bcd_pair_type pair_inc(input ccc_pkg::bcd_pair_type p);
      ccc_pkg::bcd_pair_type r;
      if (p.units == 4'd9) begin
         r.tens  = p.tens + 4'd1;
         r.units = 4'd0;
      end else begin
         r.tens  = p.tens;
         r.units = p.units + 4'd1;
      end
      return r;
   endfunction

   function automatic ccc_pkg::year_bcd_type year_inc(input ccc_pkg::year_bcd_type y);
      ccc_pkg::year_bcd_type r;
      logic                  carry;
      r     = y;
      carry = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (carry) begin
            if (y[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i]  = y[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   logic [7:0]            tick_ff, tick_in, tick_inc;
   ccc_pkg::bcd_pair_type sec_ff, sec_in;
   ccc_pkg::bcd_pair_type min_ff, min_in;
   ccc_pkg::bcd_pair_type hour_ff, hour_in;
   ccc_pkg::bcd_pair_type day_ff, day_in;
   ccc_pkg::bcd_pair_type mon_ff, mon_in;
   ccc_pkg::year_bcd_type year_ff, year_in;
   logic                  date_ff, date_in;
   logic                  screen_ff, screen_in;
   logic                  advance;
   logic                  sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;
   logic                  show_date;

   assign tick_inc  = tick_ff + 8'd1;
   assign sec_wrap  = pair_value(sec_ff) >= 7'd59;
   assign min_wrap  = pair_value(min_ff) >= 7'd59;
   assign hour_wrap = pair_value(hour_ff) >= 7'd23;
   assign day_wrap  = pair_value(day_ff) >= {2'b00, csr.days_per_month};
   assign mon_wrap  = pair_value(mon_ff) >= csr.months_per_year;

   always_comb begin
      tick_in   = tick_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      mon_in    = mon_ff;
      year_in   = year_ff;
      date_in   = date_ff;
      screen_in = screen_ff;
      advance   = 1'b0;
      if (step) begin
         case (action)
            ccc_pkg::ACT_TICK: begin
               if (tick_inc >= csr.ticks_per_second) begin
                  tick_in = 8'd0;
                  advance = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            ccc_pkg::ACT_CHAR: begin
            end
            ccc_pkg::ACT_MODE: begin
               date_in = ~date_ff;
            end
            ccc_pkg::ACT_SCREEN: begin
               screen_in = ~screen_ff;
            end
            default: begin
            end
         endcase
      end
      if (advance) begin
         sec_in = sec_wrap ? PAIR_ZERO : pair_inc(sec_ff);
         if (sec_wrap) begin
            min_in = min_wrap ? PAIR_ZERO : pair_inc(min_ff);
            if (min_wrap) begin
               hour_in = hour_wrap ? PAIR_ZERO : pair_inc(hour_ff);
               if (hour_wrap) begin
                  day_in = day_wrap ? PAIR_ONE : pair_inc(day_ff);
                  if (day_wrap) begin
                     mon_in = mon_wrap ? PAIR_ONE : pair_inc(mon_ff);
                     if (mon_wrap) begin
                        year_in = year_inc(year_ff);
                     end
                  end
               end
            end
         end
      end
      if (frame.load) begin
         hour_in = frame.hours;
         min_in  = frame.minutes;
         sec_in  = frame.seconds;
         day_in  = frame.days;
         mon_in  = frame.months;
         year_in = frame.year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= 8'd0;
         sec_ff    <= PAIR_ZERO;
         min_ff    <= PAIR_ZERO;
         hour_ff   <= PAIR_ZERO;
         day_ff    <= PAIR_ONE;
         mon_ff    <= PAIR_ONE;
         year_ff   <= YEAR_RESET;
         date_ff   <= 1'b0;
         screen_ff <= 1'b1;
      end else begin
         tick_ff   <= tick_in;
         sec_ff    <= sec_in;
         min_ff    <= min_in;
         hour_ff   <= hour_in;
         day_ff    <= day_in;
         mon_ff    <= mon_in;
         year_ff   <= year_in;
         date_ff   <= date_in;
         screen_ff <= screen_in;
      end
   end

   assign show_date = date_in && !frame.load;

   always_comb begin
      if (show_date) begin
         result.digit_a = day_in.tens;
         result.digit_b = day_in.units;
         result.digit_c = mon_in.tens;
         result.digit_d = mon_in.units;
         result.digit_e = year_in[3];
         result.digit_f = year_in[2];
         result.digit_g = year_in[1];
         result.digit_h = year_in[0];
      end else begin
         result.digit_a = hour_in.tens;
         result.digit_b = hour_in.units;
         result.digit_c = ccc_pkg::DIGIT_DASH;
         result.digit_d = min_in.tens;
         result.digit_e = min_in.units;
         result.digit_f = ccc_pkg::DIGIT_DASH;
         result.digit_g = sec_in.tens;
         result.digit_h = sec_in.units;
      end
      result.shows_date = show_date;
      result.display_on = screen_in;
      result.refresh    = advance | frame.load;
   end

endmodule

FILE: design/clock_calendar_counter.sv
// An accepted item passes the input register, then the result register, to the outputs.
// One item per cycle unless stalled; the counter update and digit select sit in one stage.
// Backpressure on rsp_ready stalls the input register and then req_ready.
// Reset (synchronous): registers 10/30/12, clock 00:00:00 on 01-01-1971, time view, display on.
`include "assert_macros.svh"

module clock_calendar_counter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_serial_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_digit_a,
   output logic [3:0] rsp_digit_b,
   output logic [3:0] rsp_digit_c,
   output logic [3:0] rsp_digit_d,
   output logic [3:0] rsp_digit_e,
   output logic [3:0] rsp_digit_f,
   output logic [3:0] rsp_digit_g,
   output logic [3:0] rsp_digit_h,
   output logic       rsp_shows_date,
   output logic       rsp_display_on,
   output logic       rsp_refresh,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic                    pipe_valid_ff;
   logic [1:0]              pipe_action_ff;
   logic [7:0]              pipe_char_ff;
   logic                    step;
   logic                    rsp_valid_ff;
   ccc_pkg::result_type     rsp_ff;
   ccc_pkg::result_type     result;
   ccc_pkg::frame_load_type frame;
   ccc_pkg::csr_type        csr_ff;

   assign step      = pipe_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pipe_valid_ff || step;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else if (req_ready) begin
         pipe_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pipe_action_ff <= req_action;
         pipe_char_ff   <= req_serial_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.ticks_per_second <= 8'd10;
         csr_ff.days_per_month   <= 5'd30;
         csr_ff.months_per_year  <= 7'd12;
      end else if (csr_valid) begin
         unique case (csr_index)
            ccc_pkg::CSR_TICKS_PER_SECOND: csr_ff.ticks_per_second <= csr_wdata;
            ccc_pkg::CSR_DAYS_PER_MONTH:   csr_ff.days_per_month   <= csr_wdata[4:0];
            ccc_pkg::CSR_MONTHS_PER_YEAR:  csr_ff.months_per_year  <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   ccc_frame_rx u_frame_rx (
      .clock       (clock),
      .reset       (reset),
      .char_valid  (step && (pipe_action_ff == ccc_pkg::ACT_CHAR)),
      .serial_char (pipe_char_ff),
      .frame       (frame)
   );

   ccc_time_core u_time_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .action (pipe_action_ff),
      .frame  (frame),
      .csr    (csr_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_a    = rsp_ff.digit_a;
   assign rsp_digit_b    = rsp_ff.digit_b;
   assign rsp_digit_c    = rsp_ff.digit_c;
   assign rsp_digit_d    = rsp_ff.digit_d;
   assign rsp_digit_e    = rsp_ff.digit_e;
   assign rsp_digit_f    = rsp_ff.digit_f;
   assign rsp_digit_g    = rsp_ff.digit_g;
   assign rsp_digit_h    = rsp_ff.digit_h;
   assign rsp_shows_date = rsp_ff.shows_date;
   assign rsp_display_on = rsp_ff.display_on;
   assign rsp_refresh    = rsp_ff.refresh;

   `ASSERT_CLK(a_full_stall, (pipe_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
   `ASSERT_CLK(a_step_gives_rsp, step |=> rsp_valid_ff)
   `ASSERT_CLK(a_time_dashes, (rsp_valid_ff && !rsp_ff.shows_date) |->
      (rsp_ff.digit_c == ccc_pkg::DIGIT_DASH) && (rsp_ff.digit_f == ccc_pkg::DIGIT_DASH))

endmodule
